[hdl/yuvab_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV420 text alpha blend package
// Shared types, register indexes and arithmetic helpers of the blend core.
// ----------------------------------------------------------------------------
package yuvab_pkg;

   localparam int unsigned SAMPLE_W   = 8;
   localparam int unsigned PRODUCT_W  = 2 * SAMPLE_W;
   localparam int unsigned LUMA_LANES = 4;
   localparam int unsigned REQ_DATA_W = 112;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [SAMPLE_W-1:0] ALPHA_FULL     = 8'd255;
   localparam logic [SAMPLE_W-1:0] CHROMA_DEFAULT = 8'd128;

   typedef logic [SAMPLE_W-1:0]  sample_type;
   typedef logic [PRODUCT_W-1:0] product_type;

   typedef enum logic [1:0] {
      REG_OUTLINE_LUMA = 2'd0,
      REG_FILL_LUMA    = 2'd1,
      REG_CHROMA_VALUE = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef struct packed {
      sample_type outline_luma;
      sample_type fill_luma;
      sample_type chroma_value;
   } cfg_type;

   // t*a + x*(255-a); never exceeds 255*255.
   function automatic product_type blend_product(input sample_type x, input sample_type t,
                                                 input sample_type a);
      product_type pt;
      product_type px;
      pt = product_type'(t) * product_type'(a);
      px = product_type'(x) * product_type'(ALPHA_FULL - a);
      return pt + px;
   endfunction

   // Exact division by 255 for any value up to 255*255.
   function automatic sample_type div255(input product_type p);
      logic [PRODUCT_W:0] s;
      s = {1'b0, p} + {{PRODUCT_W{1'b0}}, 1'b1} + {{(SAMPLE_W+1){1'b0}}, p[PRODUCT_W-1:SAMPLE_W]};
      return s[PRODUCT_W-1:SAMPLE_W];
   endfunction

   // Rounded mean of four alpha bytes.
   function automatic sample_type mean4(input logic [4*SAMPLE_W-1:0] q);
      logic [SAMPLE_W+1:0] s;
      s = {2'b00, q[7:0]} + {2'b00, q[15:8]} + {2'b00, q[23:16]} + {2'b00, q[31:24]}
          + 10'd2;
      return s[SAMPLE_W+1:2];
   endfunction

endpackage

[hdl/yuv420_text_alpha_blend_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV420 text alpha blend core
// Blends one 2x2 I420 block per item toward the outline and fill targets.
// ----------------------------------------------------------------------------
// The core takes one item every clock cycle, but the whole pipeline holds
// while a result waits on rsp_tready, so req_tready follows rsp_tready
// whenever the output stage is full. Each item runs through a five-stage
// pipeline: an input stage that also forms the rounded chroma alpha means,
// then per sample a multiply stage and a divide-by-255 stage for the outline
// pass and the same pair for the fill pass. Target values are to be written
// through the APB port only while the core is idle; the core does not check.
module yuv420_text_alpha_blend_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // luma_quad[31:0], u_in[39:32], v_in[47:40], outline_alpha_quad[79:48],
   // fill_alpha_quad[111:80]
   input  logic [yuvab_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // luma_quad_out[31:0], u_out[39:32], v_out[47:40]
   output logic [yuvab_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [yuvab_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [yuvab_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [yuvab_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready
);
   import yuvab_pkg::*;

   localparam int unsigned DEPTH = 5;

   cfg_type                 cfg;
   logic                    en;
   logic [DEPTH-1:0]        valid_ff, valid_in;
   logic [31:0]             luma_a_ff;
   sample_type              u_a_ff;
   sample_type              v_a_ff;
   logic [31:0]             oa_a_ff;
   logic [31:0]             fa_a_ff;
   sample_type              om_a_ff, om_in;
   sample_type              fm_a_ff, fm_in;
   sample_type              luma_out [LUMA_LANES];
   sample_type              u_out;
   sample_type              v_out;

   yuvab_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign en         = ~valid_ff[DEPTH-1] | rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[DEPTH-1];
   assign valid_in   = {valid_ff[DEPTH-2:0], req_tvalid};
   assign om_in      = mean4(req_tdata[79:48]);
   assign fm_in      = mean4(req_tdata[111:80]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         luma_a_ff <= req_tdata[31:0];
         u_a_ff    <= req_tdata[39:32];
         v_a_ff    <= req_tdata[47:40];
         oa_a_ff   <= req_tdata[79:48];
         fa_a_ff   <= req_tdata[111:80];
         om_a_ff   <= om_in;
         fm_a_ff   <= fm_in;
      end
   end

   for (genvar k = 0; k < LUMA_LANES; k++) begin : g_luma
      yuvab_lane u_lane (
         .clock (clock),
         .en    (en),
         .x     (luma_a_ff[8*k +: 8]),
         .a1    (oa_a_ff[8*k +: 8]),
         .t1    (cfg.outline_luma),
         .a2    (fa_a_ff[8*k +: 8]),
         .t2    (cfg.fill_luma),
         .y     (luma_out[k])
      );
   end

   yuvab_lane u_lane_u (
      .clock (clock),
      .en    (en),
      .x     (u_a_ff),
      .a1    (om_a_ff),
      .t1    (cfg.chroma_value),
      .a2    (fm_a_ff),
      .t2    (cfg.chroma_value),
      .y     (u_out)
   );

   yuvab_lane u_lane_v (
      .clock (clock),
      .en    (en),
      .x     (v_a_ff),
      .a1    (om_a_ff),
      .t1    (cfg.chroma_value),
      .a2    (fm_a_ff),
      .t2    (cfg.chroma_value),
      .y     (v_out)
   );

   assign rsp_tdata = {v_out, u_out, luma_out[3], luma_out[2], luma_out[1], luma_out[0]};

endmodule

[hdl/yuvab_csr.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV420 text alpha blend register file
// APB-style access to the outline, fill and chroma target values.
// ----------------------------------------------------------------------------
module yuvab_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [yuvab_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [yuvab_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [yuvab_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                               csr_pready,
   output yuvab_pkg::cfg_type                 cfg
);
   import yuvab_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_OUTLINE_LUMA: cfg_in.outline_luma = csr_pwdata[7:0];
            REG_FILL_LUMA:    cfg_in.fill_luma    = csr_pwdata[7:0];
            REG_CHROMA_VALUE: cfg_in.chroma_value = csr_pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_OUTLINE_LUMA: csr_prdata = {24'd0, cfg_ff.outline_luma};
         REG_FILL_LUMA:    csr_prdata = {24'd0, cfg_ff.fill_luma};
         REG_CHROMA_VALUE: csr_prdata = {24'd0, cfg_ff.chroma_value};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.outline_luma <= 8'd0;
         cfg_ff.fill_luma    <= ALPHA_FULL;
         cfg_ff.chroma_value <= CHROMA_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hdl/yuvab_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV420 text alpha blend lane
// Two blend passes on one sample: multiply, divide by 255, multiply, divide.
// ----------------------------------------------------------------------------
module yuvab_lane (
   input  logic                   clock,
   input  logic                   en,
   input  yuvab_pkg::sample_type  x,
   input  yuvab_pkg::sample_type  a1,
   input  yuvab_pkg::sample_type  t1,
   input  yuvab_pkg::sample_type  a2,
   input  yuvab_pkg::sample_type  t2,
   output yuvab_pkg::sample_type  y
);
   import yuvab_pkg::*;

   product_type p1_ff, p1_in;
   sample_type  a2_b_ff;
   sample_type  q1_ff, q1_in;
   sample_type  a2_c_ff;
   product_type p2_ff, p2_in;
   sample_type  y_ff, y_in;

   assign p1_in = blend_product(x, t1, a1);
   assign q1_in = div255(p1_ff);
   assign p2_in = blend_product(q1_ff, t2, a2_c_ff);
   assign y_in  = div255(p2_ff);
   assign y     = y_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff   <= p1_in;
         a2_b_ff <= a2;
         q1_ff   <= q1_in;
         a2_c_ff <= a2_b_ff;
         p2_ff   <= p2_in;
         y_ff    <= y_in;
      end
   end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YUV420 text alpha blend core testbench
// Streams 2x2 I420 blocks with outline and fill alphas into the core under
// several target settings and compares every returned block with an
// in-bench prediction of the two-pass luma and chroma blend. Both stream
// sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
   import yuvab_pkg::*;

   localparam int unsigned MAX_GAP         = 18;
   localparam int unsigned STALL_LIMIT     = 5000;
   localparam int unsigned HOLD_AT         = 300;
   localparam int unsigned HOLD_LEN        = 400;
   localparam int unsigned PHASES          = 6;
   localparam int unsigned ITEMS_PER_PHASE = 125;
   localparam int unsigned TAIL_CYCLES     = 20;

   typedef struct packed {
      logic [31:0] fill_alpha;
      logic [31:0] outline_alpha;
      sample_type  v;
      sample_type  u;
      logic [31:0] luma;
   } block_in_type;

   typedef struct packed {
      sample_type  v;
      sample_type  u;
      logic [31:0] luma;
   } block_out_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cfg_type       targets;
   block_in_type  pending_blocks[$];
   block_out_type expected_pixels[$];
   block_in_type  offered_block;
   bit            send_busy      = 1'b0;
   bit            burst_mode     = 1'b0;
   int unsigned   send_wait      = 0;
   int unsigned   recv_wait      = 0;
   int unsigned   hold_left      = 0;
   int unsigned   rsp_count      = 0;
   int unsigned   stall_cycles   = 0;
   int unsigned   mismatch_count = 0;

   yuv420_text_alpha_blend_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic sample_type blend_sample(input sample_type x, input sample_type t,
                                               input sample_type a);
      int unsigned full;
      int unsigned acc;
      full = ALPHA_FULL;
      acc  = int'(t) * int'(a) + int'(x) * (full - int'(a));
      return sample_type'(acc / full);
   endfunction

   function automatic sample_type alpha_mean(input logic [31:0] q);
      int unsigned total;
      total = q[7:0] + q[15:8] + q[23:16] + q[31:24];
      return sample_type'((total + 2) / 4);
   endfunction

   function automatic block_out_type predict_blend(input block_in_type b);
      block_out_type r;
      sample_type    y;
      sample_type    oc;
      sample_type    fc;
      for (int k = 0; k < LUMA_LANES; k++) begin
         y = b.luma[8*k +: 8];
         y = blend_sample(y, targets.outline_luma, b.outline_alpha[8*k +: 8]);
         y = blend_sample(y, targets.fill_luma, b.fill_alpha[8*k +: 8]);
         r.luma[8*k +: 8] = y;
      end
      oc  = alpha_mean(b.outline_alpha);
      fc  = alpha_mean(b.fill_alpha);
      r.u = blend_sample(blend_sample(b.u, targets.chroma_value, oc), targets.chroma_value, fc);
      r.v = blend_sample(blend_sample(b.v, targets.chroma_value, oc), targets.chroma_value, fc);
      return r;
   endfunction

   function automatic block_in_type make_block(input logic [31:0] luma, input sample_type u,
                                               input sample_type v, input logic [31:0] oa,
                                               input logic [31:0] fa);
      block_in_type b;
      b.luma          = luma;
      b.u             = u;
      b.v             = v;
      b.outline_alpha = oa;
      b.fill_alpha    = fa;
      return b;
   endfunction

   // Alpha words lean on the opaque and transparent ends, as rendered text does.
   function automatic logic [31:0] random_alpha();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(0, 3) != 0) begin
         for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 3))
               0:       w[8*k +: 8] = 8'd0;
               1:       w[8*k +: 8] = ALPHA_FULL;
               2:       w[8*k +: 8] = sample_type'($urandom_range(1, 254));
               default: w[8*k +: 8] = sample_type'($urandom);
            endcase
         end
      end
      return w;
   endfunction

   task automatic write_register(input reg_index_type idx, input sample_type value);
      logic [CSR_DATA_W-1:0] data;
      data       = $urandom;
      data[7:0]  = value;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_OUTLINE_LUMA: targets.outline_luma = value;
         REG_FILL_LUMA:    targets.fill_luma    = value;
         REG_CHROMA_VALUE: targets.chroma_value = value;
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_blocks.size() != 0 || send_busy || expected_pixels.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : driver
      if (reset) begin
         req_tvalid <= 1'b0;
         send_busy  = 1'b0;
         send_wait  = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_pixels.push_back(predict_blend(offered_block));
            send_busy = 1'b0;
            send_wait = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (!send_busy) begin
            if (send_wait > 0)
               send_wait--;
            else if (pending_blocks.size() != 0) begin
               offered_block = pending_blocks.pop_front();
               send_busy     = 1'b1;
            end
         end
         req_tvalid <= send_busy;
         req_tdata  <= offered_block;
      end
   end

   always @(posedge clock) begin : monitor
      block_out_type seen;
      block_out_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait  = 0;
         hold_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata;
            rsp_count++;
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $time, seen);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (seen.luma !== want.luma) begin
                  $display("%0t: luma_quad_out expected %h actual %h", $time, want.luma,
                           seen.luma);
                  mismatch_count++;
               end
               if (seen.u !== want.u) begin
                  $display("%0t: u_out expected %h actual %h", $time, want.u, seen.u);
                  mismatch_count++;
               end
               if (seen.v !== want.v) begin
                  $display("%0t: v_out expected %h actual %h", $time, want.v, seen.v);
                  mismatch_count++;
               end
            end
            recv_wait = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
            if (rsp_count == HOLD_AT)
               hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin : sequencer
      cfg_type setting;
      targets.outline_luma = 8'd0;
      targets.fill_luma    = ALPHA_FULL;
      targets.chroma_value = CHROMA_DEFAULT;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed blocks under the reset targets: transparent and opaque
      // alphas, per-lane extremes and the rounding edges of the chroma mean.
      pending_blocks.push_back(make_block(32'h0000_0000, 8'h00, 8'h00, 32'h0, 32'h0));
      pending_blocks.push_back(make_block(32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'h0, 32'h0));
      pending_blocks.push_back(make_block(32'h0000_0000, 8'h00, 8'h00, 32'hFFFF_FFFF, 32'h0));
      pending_blocks.push_back(make_block(32'hFFFF_FFFF, 8'hFF, 8'h00, 32'h0, 32'hFFFF_FFFF));
      pending_blocks.push_back(make_block(32'h1234_5678, 8'h80, 8'h7F, 32'hFFFF_FFFF,
                                          32'hFFFF_FFFF));
      pending_blocks.push_back(make_block(32'h1234_5678, 8'h80, 8'h7F, 32'h0000_00FF,
                                          32'hFF00_0000));
      pending_blocks.push_back(make_block(32'hFFFF_FFFF, 8'h00, 8'hFF, 32'hFF00_FF00,
                                          32'h00FF_00FF));
      pending_blocks.push_back(make_block(32'h00FF_00FF, 8'hFF, 8'h00, 32'h0100_0000,
                                          32'h0101_0000));
      pending_blocks.push_back(make_block(32'hFF00_FF00, 8'h01, 8'hFE, 32'h0200_0000,
                                          32'h0000_0001));
      pending_blocks.push_back(make_block(32'hA5A5_A5A5, 8'h5A, 8'hA5, 32'h8080_8080,
                                          32'h8080_8080));
      pending_blocks.push_back(make_block(32'h0102_0304, 8'hC3, 8'h3C, 32'hFEFE_FEFE,
                                          32'h7F7F_7F80));
      pending_blocks.push_back(make_block(32'h00FF_00FF, 8'hFF, 8'h00, 32'hFFFF_FF00,
                                          32'h0000_0000));
      pending_blocks.push_back(make_block(32'h8040_2010, 8'h7F, 8'h80, 32'h0303_0303,
                                          32'h0101_0101));
      pending_blocks.push_back(make_block(32'h55AA_55AA, 8'hAA, 8'h55, 32'h01FF_FE00,
                                          32'hFE01_00FF));

      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0:       setting = '{8'd0, 8'd0, 8'd0};
            1:       setting = '{8'd255, 8'd255, 8'd255};
            2:       setting = '{8'd255, 8'd0, 8'd0};
            3:       setting = '{8'd0, 8'd255, 8'd255};
            default: setting = 24'($urandom);
         endcase
         write_register(REG_OUTLINE_LUMA, setting.outline_luma);
         write_register(REG_FILL_LUMA, setting.fill_luma);
         write_register(REG_CHROMA_VALUE, setting.chroma_value);
         write_register(REG_UNUSED, sample_type'($urandom));
         burst_mode = (p == 4);
         for (int i = 0; i < ITEMS_PER_PHASE; i++)
            pending_blocks.push_back(make_block($urandom, sample_type'($urandom),
                                                sample_type'($urandom), random_alpha(),
                                                random_alpha()));
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

[files.f]
hdl/yuvab_pkg.sv
hdl/yuvab_csr.sv
hdl/yuvab_lane.sv
hdl/yuv420_text_alpha_blend_core.sv
bench/tb.sv
